// ===== rtl/core/three_level_priority_queue_assert.svh =====
// Assertion macros for the checker in rtl/core/tlpq_checker.sv.
// Each macro asserts one clocked property, disabled while arst_n is low.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define TLPQ_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("tlpq assertion failed");

// Next-cycle implication.
`define TLPQ_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tlpq assertion failed");

`endif

// ===== rtl/core/tlpq_pkg.sv =====
package tlpq_pkg;

	localparam int unsigned ID_W  = 16;
	localparam int unsigned LVL_W = 2;
	localparam int unsigned OCC_W = 7;

	typedef enum logic [1:0] {
		CMD_ENQ = 2'd0,
		CMD_DEQ = 2'd1
	} cmd_code_t;

	typedef enum logic [LVL_W-1:0] {
		LVL_CRITICAL = 2'd0,
		LVL_SERIOUS  = 2'd1,
		LVL_NORMAL   = 2'd2
	} lvl_code_t;

	typedef enum logic [1:0] {
		ST_ADDED  = 2'd0,
		ST_SERVED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [LVL_W-1:0] lvl;
		logic [ID_W-1:0]  id;
	} entry_t;

	// Broadcast to every cell for the beat being applied.
	typedef struct packed {
		logic             ins;
		logic             pop;
		logic [LVL_W-1:0] lvl;
		logic [ID_W-1:0]  id;
	} ctrl_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [ID_W-1:0]  served_id;
		logic [OCC_W-1:0] occupancy;
	} result_t;

endpackage

// ===== rtl/core/tlpq_req_if.sv =====
interface tlpq_req_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [tlpq_pkg::ID_W-1:0]     entry_id;
	logic [tlpq_pkg::LVL_W-1:0]    urgency;

	modport source (output valid, output command, output entry_id, output urgency,
		input ready);
	modport sink (input valid, input command, input entry_id, input urgency,
		output ready);
endinterface

// ===== rtl/core/tlpq_rsp_if.sv =====
interface tlpq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [tlpq_pkg::ID_W-1:0]     served_id;
	logic [tlpq_pkg::OCC_W-1:0]    occupancy;

	modport source (output valid, output status, output served_id, output occupancy,
		input ready);
	modport sink (input valid, input status, input served_id, input occupancy,
		output ready);
endinterface

// ===== rtl/core/tlpq_cell.sv =====
// One slot of the sorted row. Cell 0 is the head.
module tlpq_cell (
	input  logic             clk,
	input  tlpq_pkg::ctrl_t  ctrl,
	input  logic             occ,
	input  tlpq_pkg::entry_t up_entry,
	input  logic             up_behind,
	input  tlpq_pkg::entry_t dn_entry,
	output tlpq_pkg::entry_t entry,
	output logic             behind
);

	tlpq_pkg::entry_t entry_q;

	// New entry goes behind this one when held and at equal or higher urgency.
	assign behind = occ && (entry_q.lvl <= ctrl.lvl);
	assign entry  = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!behind) begin
				if (up_behind) begin
					entry_q <= '{lvl: ctrl.lvl, id: ctrl.id};
				end else begin
					entry_q <= up_entry;
				end
			end
		end else if (ctrl.pop) begin
			entry_q <= dn_entry;
		end
	end

endmodule

// ===== rtl/core/three_level_priority_queue.sv =====
// Three-level priority queue of up to DEPTH entries (16-bit identifier plus
// urgency: critical, serious, normal; code three counts as normal). Entries
// sit in a row of cells sorted by urgency, first in, first out within one
// level. Each req beat (command 0 enqueue, 1 dequeue) yields exactly one rsp
// beat with status (added, served, empty, full), the served identifier (0
// unless served) and the occupancy after the beat. One req beat is taken per
// cycle while req.ready is high; its result goes to the output register, or
// to the skid while an earlier result waits. All cells compare their urgency
// with the incoming one at once and shift by one place toward their neighbor,
// so the insert position needs no search. An output register plus a one-beat
// skid keep req.ready high while a single result waits on rsp; req.ready drops
// only when two results are waiting. The slot contents need no clearing after
// reset: only the first occupancy cells are ever read.
module three_level_priority_queue #(
	parameter int unsigned DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	tlpq_req_if.sink   req,
	tlpq_rsp_if.source rsp
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]  count_q;
	tlpq_pkg::ctrl_t   ctrl;
	tlpq_pkg::entry_t  cell_entry [DEPTH];
	logic              cell_behind [DEPTH];
	logic              cell_occ [DEPTH];
	logic              req_fire;
	logic              full;
	logic              empty;
	logic [1:0]        lvl_clamped;
	tlpq_pkg::result_t res;
	logic [CNT_W-1:0]  count_next;

	// Output register and skid stage.
	tlpq_pkg::result_t out_q;
	tlpq_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              out_taken;

	assign req.ready = !skid_valid_q;
	assign req_fire  = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	// Fold the unused urgency code into normal.
	assign lvl_clamped = (req.urgency > 2'(tlpq_pkg::LVL_NORMAL)) ?
		2'(tlpq_pkg::LVL_NORMAL) : req.urgency;

	always_comb begin
		ctrl.ins = req_fire && (req.command == 1'(tlpq_pkg::CMD_ENQ)) && !full;
		ctrl.pop = req_fire && (req.command == 1'(tlpq_pkg::CMD_DEQ)) && !empty;
		ctrl.lvl = lvl_clamped;
		ctrl.id  = req.entry_id;
	end

	// Row of cells: each sees its upper and lower neighbor only.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		tlpq_pkg::entry_t up_entry;
		tlpq_pkg::entry_t dn_entry;
		logic             up_behind;

		assign cell_occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			// Head has nothing above: a new entry that passes it lands here.
			assign up_entry  = cell_entry[0];
			assign up_behind = 1'b1;
		end else begin : g_body
			assign up_entry  = cell_entry[i-1];
			assign up_behind = cell_behind[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			// Tail refills with its own stale content; it is then unoccupied.
			assign dn_entry = cell_entry[i];
		end else begin : g_inner
			assign dn_entry = cell_entry[i+1];
		end

		tlpq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (cell_occ[i]),
			.up_entry  (up_entry),
			.up_behind (up_behind),
			.dn_entry  (dn_entry),
			.entry     (cell_entry[i]),
			.behind    (cell_behind[i])
		);
	end

	// Result of the accepted beat.
	always_comb begin
		count_next    = count_q;
		res.served_id = '0;
		if (req.command == 1'(tlpq_pkg::CMD_ENQ)) begin
			if (full) begin
				res.status = tlpq_pkg::ST_FULL;
			end else begin
				res.status = tlpq_pkg::ST_ADDED;
				count_next = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				res.status = tlpq_pkg::ST_EMPTY;
			end else begin
				res.status    = tlpq_pkg::ST_SERVED;
				res.served_id = cell_entry[0].id;
				count_next    = count_q - CNT_W'(1);
			end
		end
		res.occupancy = tlpq_pkg::OCC_W'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (req_fire) begin
			count_q <= count_next;
		end
	end

	assign out_taken = out_valid_q && rsp.ready;

	// Feed the output register from the skid first, then from a new beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_taken) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (req_fire) begin
			if (!out_valid_q || out_taken) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_taken) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_taken) begin
				out_q <= skid_q;
			end
		end else if (req_fire) begin
			if (!out_valid_q || out_taken) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_q.status;
	assign rsp.served_id = out_q.served_id;
	assign rsp.occupancy = out_q.occupancy;

endmodule

// ===== rtl/core/tlpq_checker.sv =====
`include "three_level_priority_queue_assert.svh"

module tlpq_checker #(
	parameter int unsigned DEPTH = 64
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [1:0]                   rsp_status,
	input logic [tlpq_pkg::ID_W-1:0]    rsp_served_id,
	input logic [tlpq_pkg::OCC_W-1:0]   rsp_occupancy
);

	localparam logic [tlpq_pkg::OCC_W-1:0] FULL_OCC = tlpq_pkg::OCC_W'(DEPTH);

	tlpq_pkg::result_t rsp_beat;
	logic              rsp_stall;
	logic              rsp_unserved;
	logic              rsp_full;
	logic              rsp_empty;

	assign rsp_beat     = {rsp_status, rsp_served_id, rsp_occupancy};
	assign rsp_stall    = rsp_valid && !rsp_ready;
	assign rsp_unserved = rsp_valid && (rsp_status != 2'(tlpq_pkg::ST_SERVED));
	assign rsp_full     = rsp_valid && (rsp_status == 2'(tlpq_pkg::ST_FULL));
	assign rsp_empty    = rsp_valid && (rsp_status == 2'(tlpq_pkg::ST_EMPTY));

	// Hold a stalled rsp beat.
	`TLPQ_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_beat))

	`TLPQ_ASSERT_NOW(a_id_zero, rsp_unserved, rsp_served_id == '0)

	`TLPQ_ASSERT_NOW(a_full_occ, rsp_full, rsp_occupancy == FULL_OCC)

	`TLPQ_ASSERT_NOW(a_empty_occ, rsp_empty, rsp_occupancy == '0)

endmodule

bind three_level_priority_queue tlpq_checker #(.DEPTH(DEPTH)) u_tlpq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_served_id (rsp.served_id),
	.rsp_occupancy (rsp.occupancy)
);

// ===== bench/tlpq_checker.sv =====
`timescale 1ns / 100ps

// Watch both channels, keep a shadow of the sorted entry row and compare
// every rsp beat with the oldest awaited result.
module tlpq_bench_checker #(
	parameter int unsigned DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	tlpq_req_if         req_mon,
	tlpq_rsp_if         rsp_mon,
	output int unsigned mismatch_total,
	output int unsigned results_owed
);

	tlpq_pkg::entry_t  held_entries[$];
	tlpq_pkg::result_t awaited_results[$];
	tlpq_pkg::result_t oldest_result;

	initial begin
		mismatch_total = 0;
		results_owed   = 0;
	end

	task report_mismatch(input string note);
		$display("%0t ns: %s", $time, note);
		mismatch_total++;
	endtask

	// Apply one req beat to the shadow row and return the result it must give.
	function automatic tlpq_pkg::result_t serve_or_insert(input logic cmd,
			input logic [tlpq_pkg::ID_W-1:0] id, input logic [tlpq_pkg::LVL_W-1:0] urg);
		tlpq_pkg::result_t              r;
		tlpq_pkg::entry_t               e;
		int                             pos;
		logic [tlpq_pkg::LVL_W-1:0]     lvl;
		r   = '0;
		lvl = (urg > tlpq_pkg::LVL_NORMAL) ? tlpq_pkg::LVL_NORMAL : urg;
		if (cmd == 1'(tlpq_pkg::CMD_ENQ)) begin
			if (held_entries.size() >= DEPTH) begin
				r.status = tlpq_pkg::ST_FULL;
			end else begin
				// Go behind every entry of equal or higher urgency.
				pos = 0;
				while (pos < held_entries.size() && held_entries[pos].lvl <= lvl)
					pos++;
				e.lvl = lvl;
				e.id  = id;
				held_entries.insert(pos, e);
				r.status = tlpq_pkg::ST_ADDED;
			end
		end else if (held_entries.size() == 0) begin
			r.status = tlpq_pkg::ST_EMPTY;
		end else begin
			e           = held_entries.pop_front();
			r.served_id = e.id;
			r.status    = tlpq_pkg::ST_SERVED;
		end
		r.occupancy = tlpq_pkg::OCC_W'(held_entries.size());
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_mon.valid && req_mon.ready)
				awaited_results.push_back(serve_or_insert(req_mon.command,
					req_mon.entry_id, req_mon.urgency));
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("rsp beat with no result awaited");
				end else begin
					oldest_result = awaited_results.pop_front();
					if (rsp_mon.status !== oldest_result.status)
						report_mismatch($sformatf("status got %0d want %0d",
							rsp_mon.status, oldest_result.status));
					if (rsp_mon.served_id !== oldest_result.served_id)
						report_mismatch($sformatf("served_id got %h want %h",
							rsp_mon.served_id, oldest_result.served_id));
					if (rsp_mon.occupancy !== oldest_result.occupancy)
						report_mismatch($sformatf("occupancy got %0d want %0d",
							rsp_mon.occupancy, oldest_result.occupancy));
				end
			end
			results_owed <= awaited_results.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned DEPTH       = 64;
	// Urgency code with no level of its own; the block files it as normal.
	localparam logic [tlpq_pkg::LVL_W-1:0] LVL_SPARE = 2'd3;
	// Cycles without any beat on either channel before the run is declared hung.
	localparam int unsigned QUIET_LIMIT = 1000;
	localparam int unsigned RANDOM_BEATS = 1030;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_ALTERNATE,
		STALL_RANDOM,
		STALL_RUNS
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned mismatch_total;
	int unsigned results_owed;
	int unsigned quiet_cycles = 0;
	int unsigned burst_left = 0;
	int unsigned held_guess = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int unsigned stall_window = 0;
	int unsigned stall_phase = 0;

	tlpq_req_if req_ch ();
	tlpq_rsp_if rsp_ch ();

	three_level_priority_queue #(
		.DEPTH(DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	tlpq_bench_checker #(
		.DEPTH(DEPTH)
	) chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_mon       (req_ch),
		.rsp_mon       (rsp_ch),
		.mismatch_total(mismatch_total),
		.results_owed  (results_owed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: pick a new stall pattern whenever the window counter runs out. Runs of
	// full throughput alternate with alternating, random and long-run stalls.
	initial rsp_ch.ready = 1'b0;

	always @(posedge clk) begin
		if (stall_window == 0) begin
			stall_mode   <= stall_mode_t'($urandom_range(3, 0));
			stall_window <= 32;
		end else begin
			stall_window <= stall_window - 1;
		end
		stall_phase <= stall_phase + 1;
		case (stall_mode)
			STALL_NONE:      rsp_ch.ready <= 1'b1;
			STALL_ALTERNATE: rsp_ch.ready <= stall_phase[0];
			STALL_RANDOM:    rsp_ch.ready <= ($urandom_range(99, 0) >= 40);
			default:         rsp_ch.ready <= ((stall_phase % 9) >= 6);
		endcase
	end

	// Watchdog: any beat on either channel restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Present one req beat and hold it until the block takes it. Unless pace_sender
	// drops valid for a gap, it stays high on return so a following beat can go out back to back.
	task push_request(input logic cmd, input logic [tlpq_pkg::ID_W-1:0] id,
			input logic [tlpq_pkg::LVL_W-1:0] urg);
		req_ch.valid    <= 1'b1;
		req_ch.command  <= cmd;
		req_ch.entry_id <= id;
		req_ch.urgency  <= urg;
		do @(posedge clk); while (!req_ch.ready);
		// Track a rough fill level to steer the random part toward full and empty.
		if (cmd == 1'(tlpq_pkg::CMD_ENQ)) begin
			if (held_guess < DEPTH)
				held_guess++;
		end else if (held_guess > 0) begin
			held_guess--;
		end
		pace_sender();
	endtask

	// Sender bursts: count down the burst, then drop valid for a random gap.
	// Some gaps are zero and some bursts are long, so stretches run at full rate.
	task pace_sender;
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(80, 30)
				: $urandom_range(12, 1);
		end
	endtask

	initial begin
		logic                           filling;
		logic                           cmd;
		logic [tlpq_pkg::ID_W-1:0]      id;
		logic [tlpq_pkg::LVL_W-1:0]     urg;

		req_ch.valid    = 1'b0;
		req_ch.command  = 1'(tlpq_pkg::CMD_ENQ);
		req_ch.entry_id = '0;
		req_ch.urgency  = tlpq_pkg::LVL_CRITICAL;
		filling         = 1'b1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Dequeue on an empty queue, with junk in the ignored fields.
		push_request(1'(tlpq_pkg::CMD_DEQ), 16'hFFFF, LVL_SPARE);
		// Extreme identifiers; the spare urgency code must line up behind normal.
		push_request(1'(tlpq_pkg::CMD_ENQ), 16'h0000, tlpq_pkg::LVL_NORMAL);
		push_request(1'(tlpq_pkg::CMD_ENQ), 16'hFFFF, LVL_SPARE);
		push_request(1'(tlpq_pkg::CMD_ENQ), 16'h1234, tlpq_pkg::LVL_SERIOUS);
		push_request(1'(tlpq_pkg::CMD_ENQ), 16'hAAAA, tlpq_pkg::LVL_CRITICAL);
		// Same level twice: must leave first in, first out.
		push_request(1'(tlpq_pkg::CMD_ENQ), 16'h5555, tlpq_pkg::LVL_CRITICAL);
		push_request(1'(tlpq_pkg::CMD_ENQ), 16'h0001, tlpq_pkg::LVL_SERIOUS);
		// Drain all six and one more to hit empty again.
		push_request(1'(tlpq_pkg::CMD_DEQ), 16'h0000, tlpq_pkg::LVL_CRITICAL);
		push_request(1'(tlpq_pkg::CMD_DEQ), 16'hFFFF, tlpq_pkg::LVL_NORMAL);
		push_request(1'(tlpq_pkg::CMD_DEQ), 16'h8001, LVL_SPARE);
		push_request(1'(tlpq_pkg::CMD_DEQ), 16'h7FFE, tlpq_pkg::LVL_SERIOUS);
		push_request(1'(tlpq_pkg::CMD_DEQ), 16'h0F0F, tlpq_pkg::LVL_CRITICAL);
		push_request(1'(tlpq_pkg::CMD_DEQ), 16'hF0F0, tlpq_pkg::LVL_NORMAL);
		push_request(1'(tlpq_pkg::CMD_DEQ), 16'h00FF, LVL_SPARE);
		// Later critical entry must overtake an earlier normal one.
		push_request(1'(tlpq_pkg::CMD_ENQ), 16'h8000, tlpq_pkg::LVL_NORMAL);
		push_request(1'(tlpq_pkg::CMD_ENQ), 16'h7FFF, tlpq_pkg::LVL_CRITICAL);
		push_request(1'(tlpq_pkg::CMD_DEQ), 16'h0000, tlpq_pkg::LVL_CRITICAL);
		push_request(1'(tlpq_pkg::CMD_DEQ), 16'h0000, tlpq_pkg::LVL_CRITICAL);
		push_request(1'(tlpq_pkg::CMD_DEQ), 16'h0000, tlpq_pkg::LVL_CRITICAL);

		// Random part: swing between filling and draining so the queue hits
		// full and empty repeatedly, with mixed traffic in between.
		for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
			if (filling)
				cmd = ($urandom_range(99, 0) < 80) ? 1'(tlpq_pkg::CMD_ENQ)
					: 1'(tlpq_pkg::CMD_DEQ);
			else
				cmd = ($urandom_range(99, 0) < 80) ? 1'(tlpq_pkg::CMD_DEQ)
					: 1'(tlpq_pkg::CMD_ENQ);
			case ($urandom_range(7, 0))
				0:       id = 16'h0000;
				1:       id = 16'hFFFF;
				default: id = tlpq_pkg::ID_W'($urandom_range(16'hFFFF, 0));
			endcase
			urg = tlpq_pkg::LVL_W'($urandom_range(3, 0));
			push_request(cmd, id, urg);
			// Linger at full and empty for a few beats before turning around.
			if (filling && held_guess >= DEPTH && $urandom_range(3, 0) == 0)
				filling = 1'b0;
			else if (!filling && held_guess == 0 && $urandom_range(2, 0) == 0)
				filling = 1'b1;
			else if ($urandom_range(199, 0) == 0)
				filling = !filling;
		end

		req_ch.valid <= 1'b0;
		// Let the checker's count catch up, then drain what is still owed.
		do @(posedge clk); while (results_owed != 0);
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (mismatch_total == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tlpq_pkg.sv
rtl/core/tlpq_req_if.sv
rtl/core/tlpq_rsp_if.sv
rtl/core/tlpq_cell.sv
rtl/core/three_level_priority_queue.sv
rtl/core/tlpq_checker.sv
bench/tlpq_checker.sv
bench/tb_top.sv
